FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, held off while reset is asserted.
`define STP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check: whenever the condition holds, the consequence must hold too.
`define STP_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

`endif

FILE: sv/stp_pkg.sv
package stp_pkg;

  localparam int RPT_BITS = 24;
  localparam int NSLOT    = 3;

  localparam logic [2:0] EV_KEY_BYTE   = 3'd0;
  localparam logic [2:0] EV_VALUE_BYTE = 3'd1;
  localparam logic [2:0] EV_KEY_DONE   = 3'd2;
  localparam logic [2:0] EV_ENTRY_DONE = 3'd3;
  localparam logic [2:0] EV_CLOSED     = 3'd4;
  localparam logic [2:0] EV_WARN       = 3'd5;
  localparam logic [2:0] EV_ERROR      = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_IN_KEY    = 3'd1;
  localparam logic [2:0] ERR_NO_VALUE  = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd3;
  localparam logic [2:0] ERR_NON_ASCII = 3'd4;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  // One result word waiting to be sent.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       use_new;  // report the entry count after this byte's increment
  } slot_t;

  // Everything one input byte produces, as one queue entry.
  typedef struct packed {
    logic [1:0]               count;
    slot_t [NSLOT-1:0]        slots;
    logic [RPT_BITS-1:0]      line;
    logic [RPT_BITS-1:0]      ent_old;
    logic [RPT_BITS-1:0]      ent_new;
  } rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic slot_t mk_slot(input logic [2:0] kind, input logic [7:0] data,
                                    input logic [2:0] err, input logic use_new);
    slot_t s;
    s.kind    = kind;
    s.data    = data;
    s.err     = err;
    s.use_new = use_new;
    return s;
  endfunction

endpackage

FILE: sv/stp_front.sv
module stp_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic           cfg_utf8_mode,
  input  logic           in_valid,
  input  logic [7:0]     in_data_byte,
  input  logic           in_end_of_text,
  input  logic           q_full,
  output logic           in_ready,
  output logic           push,
  output stp_pkg::rec_t  rec
);

  typedef enum logic [2:0] {
    PH_TOP, PH_COMMENT, PH_KEY, PH_SEEK, PH_VALUE, PH_ESCAPE, PH_DONE, PH_ERROR
  } phase_t;

  phase_t                phase_r, phase_mid, phase_nxt;
  logic                  quote_r, quote_nxt;
  logic                  utf8_r;
  logic [COUNT_BITS-1:0] line_r, line_nxt, ent_r, ent_nxt;
  logic                  line_inc, ent_inc, accept;
  logic [7:0]            c;
  logic                  hi_byte;
  stp_pkg::slot_t        b_slot [3];
  stp_pkg::slot_t        t_slot [2];
  stp_pkg::slot_t        f_slot [3];
  logic [1:0]            nb, nt, j;
  logic [2:0]            ntot;

  function automatic logic [stp_pkg::RPT_BITS-1:0] rpt(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+stp_pkg::RPT_BITS-1:0] w;
    w = {{stp_pkg::RPT_BITS{1'b0}}, v};
    return w[stp_pkg::RPT_BITS-1:0];
  endfunction

  assign c        = in_data_byte;
  assign hi_byte  = c[7];
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Body of the step: what this byte does in the current phase.
  always_comb begin
    phase_mid = phase_r;
    quote_nxt = quote_r;
    line_inc  = 1'b0;
    ent_inc   = 1'b0;
    nb        = 2'd0;
    for (int i = 0; i < 3; i++) b_slot[i] = '0;
    unique case (phase_r)
      PH_TOP: begin
        if (c == stp_pkg::CH_SLASH) begin
          phase_mid = PH_COMMENT;
        end else if (c == stp_pkg::CH_RBRACE) begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_CLOSED, 8'h00, stp_pkg::ERR_NONE, 1'b0);
          nb        = 2'd1;
          phase_mid = PH_DONE;
        end else if (c == stp_pkg::CH_NL) begin
          line_inc = 1'b1;
        end else if (c == stp_pkg::CH_QUOTE) begin
          phase_mid = PH_KEY;
        end
      end
      PH_COMMENT: begin
        if (c == stp_pkg::CH_NL) begin
          line_inc  = 1'b1;
          phase_mid = PH_TOP;
        end
      end
      PH_KEY: begin
        nb = 2'd1;
        if (c == stp_pkg::CH_QUOTE) begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_KEY_DONE, 8'h00, stp_pkg::ERR_NONE, 1'b0);
          phase_mid = PH_SEEK;
        end else begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_KEY_BYTE, c, stp_pkg::ERR_NONE, 1'b0);
        end
      end
      PH_SEEK: begin
        if (c == stp_pkg::CH_QUOTE) begin
          quote_nxt = 1'b0;
          phase_mid = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (!utf8_r && hi_byte) begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ERROR, 8'h00, stp_pkg::ERR_NON_ASCII, 1'b0);
          nb        = 2'd1;
          phase_mid = PH_ERROR;
        end else if (c == stp_pkg::CH_QUOTE) begin
          quote_nxt = 1'b1;
        end else if (c == stp_pkg::CH_NL) begin
          line_inc = 1'b1;
          nb       = 2'd1;
          if (quote_r) begin
            ent_inc   = 1'b1;
            b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ENTRY_DONE, 8'h00, stp_pkg::ERR_NONE, 1'b1);
            phase_mid = PH_TOP;
          end else begin
            b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ERROR, 8'h00, stp_pkg::ERR_UNCLOSED, 1'b1);
            phase_mid = PH_ERROR;
          end
        end else if (c == stp_pkg::CH_CR) begin
          phase_mid = PH_VALUE;
        end else if (c == stp_pkg::CH_BSLASH) begin
          phase_mid = PH_ESCAPE;
        end else begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, c, stp_pkg::ERR_NONE, 1'b0);
          nb        = 2'd1;
        end
      end
      PH_ESCAPE: begin
        phase_mid = PH_VALUE;
        if (c == stp_pkg::CH_N) begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, stp_pkg::CH_NL,
                                       stp_pkg::ERR_NONE, 1'b0);
          nb        = 2'd1;
        end else if (c == stp_pkg::CH_T) begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, stp_pkg::CH_TAB,
                                       stp_pkg::ERR_NONE, 1'b0);
          nb        = 2'd1;
        end else if (c == stp_pkg::CH_QUOTE || c == stp_pkg::CH_BSLASH) begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, c, stp_pkg::ERR_NONE, 1'b0);
          nb        = 2'd1;
        end else begin
          b_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_WARN, c, stp_pkg::ERR_NONE, 1'b0);
          if (!utf8_r && hi_byte) begin
            // Latin-1 byte re-encoded as a two-byte UTF-8 sequence.
            b_slot[1] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, {2'b11, 4'b0, c[7:6]},
                                         stp_pkg::ERR_NONE, 1'b0);
            b_slot[2] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, {2'b10, c[5:0]},
                                         stp_pkg::ERR_NONE, 1'b0);
            nb        = 2'd3;
          end else begin
            b_slot[1] = stp_pkg::mk_slot(stp_pkg::EV_VALUE_BYTE, c, stp_pkg::ERR_NONE, 1'b0);
            nb        = 2'd2;
          end
        end
      end
      PH_DONE, PH_ERROR: begin
        phase_mid = phase_r;
      end
      default: begin
        phase_mid = phase_r;
      end
    endcase
  end

  // Tail of the step: end of text closes or fails, depending on where parsing stands.
  always_comb begin
    phase_nxt = phase_mid;
    nt        = 2'd0;
    t_slot[0] = '0;
    t_slot[1] = '0;
    if (in_end_of_text && phase_r != PH_DONE && phase_r != PH_ERROR) begin
      unique case (phase_mid)
        PH_TOP, PH_COMMENT: begin
          t_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_CLOSED, 8'h00, stp_pkg::ERR_NONE, 1'b1);
          nt        = 2'd1;
          phase_nxt = PH_DONE;
        end
        PH_KEY: begin
          t_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ERROR, 8'h00, stp_pkg::ERR_IN_KEY, 1'b1);
          nt        = 2'd1;
          phase_nxt = PH_ERROR;
        end
        PH_SEEK: begin
          t_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ERROR, 8'h00, stp_pkg::ERR_NO_VALUE, 1'b1);
          nt        = 2'd1;
          phase_nxt = PH_ERROR;
        end
        PH_VALUE, PH_ESCAPE: begin
          if (quote_nxt) begin
            t_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ENTRY_DONE, 8'h00, stp_pkg::ERR_NONE, 1'b1);
            t_slot[1] = stp_pkg::mk_slot(stp_pkg::EV_CLOSED, 8'h00, stp_pkg::ERR_NONE, 1'b1);
            nt        = 2'd2;
            phase_nxt = PH_DONE;
          end else begin
            t_slot[0] = stp_pkg::mk_slot(stp_pkg::EV_ERROR, 8'h00, stp_pkg::ERR_UNCLOSED, 1'b1);
            nt        = 2'd1;
            phase_nxt = PH_ERROR;
          end
        end
        PH_DONE, PH_ERROR: begin
          phase_nxt = phase_mid;
        end
        default: begin
          phase_nxt = phase_mid;
        end
      endcase
    end
  end

  wire tail_inc = in_end_of_text && quote_nxt &&
                  (phase_mid == PH_VALUE || phase_mid == PH_ESCAPE) &&
                  phase_r != PH_DONE && phase_r != PH_ERROR;

  // Merge body and tail words; a step never keeps more than three.
  always_comb begin
    j = 2'd0;
    for (int i = 0; i < 3; i++) begin
      f_slot[i] = '0;
      j = 2'(i) - nb;
      if (2'(i) < nb) begin
        f_slot[i] = b_slot[i];
      end else if (j < nt) begin
        f_slot[i] = t_slot[j[0]];
      end
    end
    ntot = {1'b0, nb} + {1'b0, nt};
  end

  always_comb begin
    line_nxt = (line_inc && line_r != '1) ? line_r + COUNT_BITS'(1) : line_r;
    ent_nxt  = ((ent_inc || tail_inc) && ent_r != '1) ? ent_r + COUNT_BITS'(1) : ent_r;
  end

  always_comb begin
    rec.count   = (ntot > 3'd3) ? 2'd3 : ntot[1:0];
    rec.line    = rpt(line_nxt);
    rec.ent_old = rpt(ent_r);
    rec.ent_new = rpt(ent_nxt);
    for (int i = 0; i < 3; i++) rec.slots[i] = f_slot[i];
  end

  assign push = accept && (ntot != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOP;
      quote_r <= 1'b0;
      line_r  <= '0;
      ent_r   <= '0;
      utf8_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        utf8_r <= cfg_utf8_mode;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        quote_r <= quote_nxt;
        line_r  <= line_nxt;
        ent_r   <= ent_nxt;
      end
    end
  end

endmodule

FILE: sv/stp_queue.sv
module stp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stp_pkg::rec_t   wr_rec,
  input  logic            pop,
  output stp_pkg::rec_t   head,
  output stp_pkg::qstat_t stat
);

  stp_pkg::rec_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/stp_back.sv
module stp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  stp_pkg::rec_t   head,
  input  stp_pkg::qstat_t stat,
  input  logic            out_ready,
  output logic            pop,
  output logic            out_valid,
  output logic [2:0]      out_event_kind,
  output logic [7:0]      out_byte_out,
  output logic [23:0]     out_line_number,
  output logic [23:0]     out_entries_done,
  output logic [2:0]      out_error_code,
  output logic            out_last_of_run
);

  logic [1:0]     idx_r;
  stp_pkg::slot_t cur;
  logic           last;

  assign cur              = head.slots[idx_r];
  assign last             = (idx_r == head.count - 2'd1);
  assign out_valid        = !stat.empty;
  assign out_event_kind   = cur.kind;
  assign out_byte_out     = cur.data;
  assign out_error_code   = cur.err;
  assign out_line_number  = head.line;
  assign out_entries_done = cur.use_new ? head.ent_new : head.ent_old;
  assign out_last_of_run  = last;
  assign pop              = out_valid && out_ready && last;

  // Walk the words of the head entry, one per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

FILE: sv/string_table_text_parser.sv
// String table text parser.
// Input channel: in_valid/in_ready carry one text byte per word (in_data_byte)
// with in_end_of_text set on the last byte. Output channel: out_valid/out_ready
// carry one event word; one input byte yields zero to three words, and
// out_last_of_run marks the last word of each byte's group.
// Configuration: cfg_valid/cfg_ready write utf8_mode; cfg_ready is always high.
// Each accepted byte's words are registered in the queue before they are sent.
// Throughput: one input byte per cycle while the queue is not full; the output
// side sends one word per cycle while out_ready is high, so the words of one
// byte go out one after another. The front classifier updates the parse
// state per accepted byte; a two-entry queue holds its words for the back end.
// When the receiver stalls, the queue fills and in_ready drops after two
// pending bytes; bytes that yield no words are still taken while room remains.
// Reset (rst_n low, synchronous) returns to the top-level phase, clears both
// counters and the queue, and selects ASCII mode. After the table is closed or
// an error is reported, further bytes are accepted but give no words.
`include "assert_macros.svh"

module string_table_text_parser #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_utf8_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_byte_out,
  output logic [23:0] out_line_number,
  output logic [23:0] out_entries_done,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  stp_pkg::rec_t   rec, head;
  stp_pkg::qstat_t stat;
  logic            push, pop;

  assign cfg_ready = 1'b1;

  stp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_utf8_mode  (cfg_utf8_mode),
    .in_valid       (in_valid),
    .in_data_byte   (in_data_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (stat.full),
    .in_ready       (in_ready),
    .push           (push),
    .rec            (rec)
  );

  stp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (rec),
    .pop    (pop),
    .head   (head),
    .stat   (stat)
  );

  stp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .stat             (stat),
    .out_ready        (out_ready),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_event_kind   (out_event_kind),
    .out_byte_out     (out_byte_out),
    .out_line_number  (out_line_number),
    .out_entries_done (out_entries_done),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

  `STP_ASSERT_IMPL(a_full_has_word, !in_ready, out_valid, "input stalled with no word pending")
  `STP_ASSERT_IMPL(a_err_code_set, out_valid && out_event_kind == stp_pkg::EV_ERROR, out_error_code != stp_pkg::ERR_NONE, "error word without a code")
  `STP_ASSERT_IMPL(a_err_code_clr, out_valid && out_event_kind != stp_pkg::EV_ERROR, out_error_code == stp_pkg::ERR_NONE, "error code on a non-error word")

endmodule

FILE: sim/testbench.sv
module testbench;

  typedef enum logic [2:0] {
    TXT_TOP, TXT_COMMENT, TXT_KEY, TXT_SEEK, TXT_VALUE, TXT_ESCAPE, TXT_DONE, TXT_ERROR
  } text_phase_t;

  typedef enum int {
    END_BRACE, END_TOP_LINE, END_IN_COMMENT, END_IN_KEY, END_BEFORE_VALUE,
    END_CLOSED_VALUE, END_OPEN_VALUE, END_TRAILING_ESCAPE, END_WIDE_ESCAPE,
    END_UNCLOSED_LINE, END_NON_ASCII
  } text_end_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [23:0] line;
    logic [23:0] entries;
    logic [2:0]  err;
    logic        last;
  } event_word_t;

  localparam logic [23:0] COUNT_MAX = {24{1'b1}};

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_utf8_mode;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_byte_out;
  logic [23:0] out_line_number;
  logic [23:0] out_entries_done;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;

  // Parser state as the testbench sees it.
  text_phase_t text_phase;
  logic        quote_in_value;
  logic [23:0] line_count;
  logic [23:0] entry_count;
  logic        utf8_now;

  event_word_t byte_events[$];
  event_word_t pending_events[$];

  int  event_mismatches = 0;
  int  bytes_fed = 0;
  bit  calm = 1'b0;
  int  hold_request = 0;
  int  ready_stall = 0;
  event_word_t seen_word;

  string_table_text_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_utf8_mode    (cfg_utf8_mode),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_byte_out     (out_byte_out),
    .out_line_number  (out_line_number),
    .out_entries_done (out_entries_done),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [23:0] bump_count(logic [23:0] c);
    return (c == COUNT_MAX) ? c : c + 24'd1;
  endfunction

  // One byte never yields more than three words; anything beyond is dropped.
  function automatic void note_event(logic [2:0] kind, logic [7:0] data, logic [2:0] err);
    event_word_t w;
    if (byte_events.size() >= stp_pkg::NSLOT) return;
    w.kind    = kind;
    w.data    = data;
    w.line    = line_count;
    w.entries = entry_count;
    w.err     = err;
    w.last    = 1'b0;
    byte_events.push_back(w);
  endfunction

  function automatic void raise_error(logic [2:0] code);
    note_event(stp_pkg::EV_ERROR, 8'h00, code);
    text_phase = TXT_ERROR;
  endfunction

  function automatic void close_entry();
    if (quote_in_value) begin
      entry_count = bump_count(entry_count);
      note_event(stp_pkg::EV_ENTRY_DONE, 8'h00, stp_pkg::ERR_NONE);
      text_phase = TXT_TOP;
    end else begin
      raise_error(stp_pkg::ERR_UNCLOSED);
    end
  endfunction

  function automatic void parse_text_byte(logic [7:0] c, logic eot);
    event_word_t tail;
    byte_events.delete();
    if (text_phase == TXT_DONE || text_phase == TXT_ERROR) return;
    case (text_phase)
      TXT_TOP: begin
        if (c == stp_pkg::CH_SLASH) text_phase = TXT_COMMENT;
        else if (c == stp_pkg::CH_RBRACE) begin
          note_event(stp_pkg::EV_CLOSED, 8'h00, stp_pkg::ERR_NONE);
          text_phase = TXT_DONE;
        end else if (c == stp_pkg::CH_NL) line_count = bump_count(line_count);
        else if (c == stp_pkg::CH_QUOTE) text_phase = TXT_KEY;
      end
      TXT_COMMENT: begin
        if (c == stp_pkg::CH_NL) begin
          line_count = bump_count(line_count);
          text_phase = TXT_TOP;
        end
      end
      TXT_KEY: begin
        if (c == stp_pkg::CH_QUOTE) begin
          note_event(stp_pkg::EV_KEY_DONE, 8'h00, stp_pkg::ERR_NONE);
          text_phase = TXT_SEEK;
        end else begin
          note_event(stp_pkg::EV_KEY_BYTE, c, stp_pkg::ERR_NONE);
        end
      end
      TXT_SEEK: begin
        if (c == stp_pkg::CH_QUOTE) begin
          quote_in_value = 1'b0;
          text_phase = TXT_VALUE;
        end
      end
      TXT_VALUE: begin
        if (!utf8_now && c[7]) raise_error(stp_pkg::ERR_NON_ASCII);
        else if (c == stp_pkg::CH_QUOTE) quote_in_value = 1'b1;
        else if (c == stp_pkg::CH_NL) begin
          line_count = bump_count(line_count);
          close_entry();
        end else if (c == stp_pkg::CH_CR) begin
        end else if (c == stp_pkg::CH_BSLASH) text_phase = TXT_ESCAPE;
        else note_event(stp_pkg::EV_VALUE_BYTE, c, stp_pkg::ERR_NONE);
      end
      TXT_ESCAPE: begin
        text_phase = TXT_VALUE;
        if (c == stp_pkg::CH_N) begin
          note_event(stp_pkg::EV_VALUE_BYTE, stp_pkg::CH_NL, stp_pkg::ERR_NONE);
        end else if (c == stp_pkg::CH_T) begin
          note_event(stp_pkg::EV_VALUE_BYTE, stp_pkg::CH_TAB, stp_pkg::ERR_NONE);
        end else if (c == stp_pkg::CH_QUOTE || c == stp_pkg::CH_BSLASH) begin
          note_event(stp_pkg::EV_VALUE_BYTE, c, stp_pkg::ERR_NONE);
        end else begin
          note_event(stp_pkg::EV_WARN, c, stp_pkg::ERR_NONE);
          if (!utf8_now && c[7]) begin
            // ASCII mode re-encodes the escaped byte as two UTF-8 bytes.
            note_event(stp_pkg::EV_VALUE_BYTE, {6'b110000, c[7:6]}, stp_pkg::ERR_NONE);
            note_event(stp_pkg::EV_VALUE_BYTE, {2'b10, c[5:0]}, stp_pkg::ERR_NONE);
          end else begin
            note_event(stp_pkg::EV_VALUE_BYTE, c, stp_pkg::ERR_NONE);
          end
        end
      end
      default: begin
      end
    endcase

    if (eot) begin
      case (text_phase)
        TXT_TOP, TXT_COMMENT: begin
          note_event(stp_pkg::EV_CLOSED, 8'h00, stp_pkg::ERR_NONE);
          text_phase = TXT_DONE;
        end
        TXT_KEY:  raise_error(stp_pkg::ERR_IN_KEY);
        TXT_SEEK: raise_error(stp_pkg::ERR_NO_VALUE);
        TXT_VALUE, TXT_ESCAPE: begin
          close_entry();
          if (text_phase == TXT_TOP) begin
            note_event(stp_pkg::EV_CLOSED, 8'h00, stp_pkg::ERR_NONE);
            text_phase = TXT_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (byte_events.size() > 0) begin
      tail = byte_events.pop_back();
      tail.last = 1'b1;
      byte_events.push_back(tail);
    end
    while (byte_events.size() > 0) pending_events.push_back(byte_events.pop_front());
  endfunction

  function automatic void report_mismatch(string what, event_word_t want, event_word_t got);
    event_mismatches++;
    if (event_mismatches <= 10) begin
      $display("%s: expected kind %0d byte %h line %0d entries %0d err %0d last %b",
               what, want.kind, want.data, want.line, want.entries, want.err, want.last);
      $display("    got      kind %0d byte %h line %0d entries %0d err %0d last %b",
               got.kind, got.data, got.line, got.entries, got.err, got.last);
    end
  endfunction

  // Every word the block sends is matched against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_word.kind    = out_event_kind;
      seen_word.data    = out_byte_out;
      seen_word.line    = out_line_number;
      seen_word.entries = out_entries_done;
      seen_word.err     = out_error_code;
      seen_word.last    = out_last_of_run;
      if (pending_events.size() == 0) report_mismatch("unexpected word", '0, seen_word);
      else if (pending_events[0] != seen_word)
        report_mismatch("wrong word", pending_events.pop_front(), seen_word);
      else void'(pending_events.pop_front());
    end
  end

  // Receiver: a random stall after each word unless calm, or a long hold on request.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_ready <= 1'b0;
        ready_stall = hold_request;
        hold_request = 0;
      end else if (ready_stall != 0) begin
        ready_stall = ready_stall - 1;
        if (ready_stall == 0) out_ready <= 1'b1;
      end else if (out_valid && out_ready) begin
        ready_stall = calm ? 0 : $urandom_range(0, 6);
        if (ready_stall != 0) out_ready <= 1'b0;
      end
    end
  end

  task automatic feed_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    parse_text_byte(b, eot);
    bytes_fed++;
  endtask

  task automatic feed_escape(input logic [7:0] b);
    feed_byte(stp_pkg::CH_BSLASH, 1'b0);
    feed_byte(b, 1'b0);
  endtask

  // Lets every expected word come out, then idles so that silent bytes settle.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_utf8_mode(input logic mode);
    cfg_valid     <= 1'b1;
    cfg_utf8_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    utf8_now = mode;
  endtask

  function automatic logic [7:0] plain_value_byte(logic wide);
    logic [7:0] b;
    do b = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
    while (b == stp_pkg::CH_NL || b == stp_pkg::CH_BSLASH || b == stp_pkg::CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  task automatic feed_key();
    int len;
    len = $urandom_range(0, 6);
    feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    repeat (len) feed_byte(byte_other_than(stp_pkg::CH_QUOTE), 1'b0);
    feed_byte(stp_pkg::CH_QUOTE, 1'b0);
  endtask

  // A complete entry: key, a few stray bytes, then a quoted value line.
  task automatic feed_entry();
    int len;
    int r;
    feed_key();
    repeat ($urandom_range(0, 2)) feed_byte(byte_other_than(stp_pkg::CH_QUOTE), 1'b0);
    feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    len = $urandom_range(0, 8);
    repeat (len) begin
      r = $urandom_range(0, 9);
      if (r < 2) feed_escape(8'($urandom_range(0, 255)));
      else if (r == 2) feed_byte(stp_pkg::CH_CR, 1'b0);
      else if (r == 3) feed_byte(stp_pkg::CH_QUOTE, 1'b0);
      else feed_byte(plain_value_byte(utf8_now), 1'b0);
    end
    feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 2)) feed_byte(plain_value_byte(utf8_now), 1'b0);
    if ($urandom_range(0, 1)) feed_byte(stp_pkg::CH_CR, 1'b0);
    feed_byte(stp_pkg::CH_NL, 1'b0);
  endtask

  task automatic feed_top_noise();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 2);
    if (r == 0) feed_byte(stp_pkg::CH_NL, 1'b0);
    else if (r == 1) begin
      feed_byte(stp_pkg::CH_SLASH, 1'b0);
      repeat ($urandom_range(0, 5)) feed_byte(byte_other_than(stp_pkg::CH_NL), 1'b0);
      feed_byte(stp_pkg::CH_NL, 1'b0);
    end else begin
      do b = 8'($urandom_range(0, 255));
      while (b == stp_pkg::CH_RBRACE || b == stp_pkg::CH_SLASH || b == stp_pkg::CH_QUOTE);
      feed_byte(b, 1'b0);
    end
  endtask

  task automatic feed_random_text(input int count);
    int target;
    target = bytes_fed + count;
    while (bytes_fed < target) begin
      if ($urandom_range(0, 3) == 0) feed_top_noise();
      else feed_entry();
    end
  endtask

  task automatic test_directed_ascii();
    // Comment holding a high byte, then a key with extremes and a newline in it.
    feed_byte(stp_pkg::CH_SLASH, 1'b0); feed_byte(8'hFF, 1'b0);
    feed_byte(stp_pkg::CH_NL, 1'b0);
    feed_byte(stp_pkg::CH_QUOTE, 1'b0); feed_byte(8'h00, 1'b0);
    feed_byte(stp_pkg::CH_NL, 1'b0);
    feed_byte(8'hFF, 1'b0); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    feed_byte(stp_pkg::CH_NL, 1'b0);
    // Value with every escape kind, an escaped newline and a carriage return.
    feed_byte(stp_pkg::CH_QUOTE, 1'b0); feed_byte(8'h7F, 1'b0);
    feed_escape(stp_pkg::CH_N); feed_escape(stp_pkg::CH_T);
    feed_escape(stp_pkg::CH_QUOTE); feed_escape(stp_pkg::CH_BSLASH);
    feed_escape(8'h71); feed_escape(8'h80); feed_escape(stp_pkg::CH_NL);
    feed_byte(stp_pkg::CH_CR, 1'b0); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    feed_byte(stp_pkg::CH_NL, 1'b0);
  endtask

  task automatic test_utf8_entries();
    feed_byte(stp_pkg::CH_QUOTE, 1'b0); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    feed_byte(8'hFF, 1'b0); feed_escape(8'hC3); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
    feed_byte(stp_pkg::CH_NL, 1'b0);
    feed_random_text(130);
  endtask

  task automatic test_backpressure();
    hold_request = 60;
    feed_random_text(35);
    hold_request = 60;
    feed_random_text(35);
  endtask

  task automatic test_ascii_random();
    feed_random_text(130);
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    feed_random_text(60);
    calm = 1'b0;
  endtask

  task automatic test_text_end();
    int pick;
    pick = $urandom_range(0, 10);
    case (pick)
      END_BRACE:    feed_byte(stp_pkg::CH_RBRACE, 1'b0);
      END_TOP_LINE: feed_byte(stp_pkg::CH_NL, 1'b1);
      END_IN_COMMENT: begin
        feed_byte(stp_pkg::CH_SLASH, 1'b0);
        feed_byte(byte_other_than(stp_pkg::CH_NL), 1'b1);
      end
      END_IN_KEY: begin
        feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(byte_other_than(stp_pkg::CH_QUOTE), 1'b1);
      end
      END_BEFORE_VALUE: begin
        feed_key();
        feed_byte(byte_other_than(stp_pkg::CH_QUOTE), 1'b1);
      end
      END_CLOSED_VALUE: begin
        feed_key(); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(plain_value_byte(1'b0), 1'b0); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(plain_value_byte(1'b0), 1'b1);
      end
      END_OPEN_VALUE: begin
        feed_key(); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(plain_value_byte(1'b0), 1'b1);
      end
      END_TRAILING_ESCAPE: begin
        feed_key(); feed_byte(stp_pkg::CH_QUOTE, 1'b0); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(stp_pkg::CH_BSLASH, 1'b1);
      end
      END_WIDE_ESCAPE: begin
        // Three words fill the run, so the entry and close words are lost.
        feed_key(); feed_byte(stp_pkg::CH_QUOTE, 1'b0); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(stp_pkg::CH_BSLASH, 1'b0); feed_byte(8'($urandom_range(128, 255)), 1'b1);
      end
      END_UNCLOSED_LINE: begin
        feed_key(); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(plain_value_byte(1'b0), 1'b0); feed_byte(stp_pkg::CH_NL, 1'b0);
      end
      default: begin
        feed_key(); feed_byte(stp_pkg::CH_QUOTE, 1'b0);
        feed_byte(8'($urandom_range(128, 255)), 1'b0);
      end
    endcase
    // The block is finished now; later bytes must stay silent.
    repeat (3) feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_utf8_mode  = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_end_of_text = 1'b0;
    text_phase     = TXT_TOP;
    quote_in_value = 1'b0;
    line_count     = 24'd0;
    entry_count    = 24'd0;
    utf8_now       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_utf8_mode(1'b0);
    test_directed_ascii();
    drain_events();
    write_utf8_mode(1'b1);
    test_utf8_entries();
    test_backpressure();
    drain_events();
    write_utf8_mode(1'b0);
    test_ascii_random();
    drain_events();
    write_utf8_mode(1'b1);
    test_steady_stream();
    drain_events();
    write_utf8_mode(1'b0);
    test_text_end();
    drain_events();
    repeat (12) @(posedge clk);

    if (event_mismatches == 0 && pending_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
